// ----- rtl/alarm_beep_pattern_sequencer_core_assert.svh -----
// Assertion helpers used by the sequencer core RTL.
`ifndef ALARM_BEEP_PATTERN_SEQUENCER_CORE_ASSERT_SVH
`define ALARM_BEEP_PATTERN_SEQUENCER_CORE_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define ABPS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("abps assertion failed");

// Next-cycle implication, held off during reset.
`define ABPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("abps assertion failed");

`endif

// ----- rtl/abps_pkg.sv -----
package abps_pkg;

  localparam int CMD_W  = 2;
  localparam int PAT_W  = 3;
  localparam int STEP_W = 2;
  localparam int WAIT_W = 11;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REQ   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESET = 2'd2;

  // Pattern codes
  localparam logic [PAT_W-1:0] PAT_OFF    = 3'd0;
  localparam logic [PAT_W-1:0] PAT_ARM    = 3'd1;
  localparam logic [PAT_W-1:0] PAT_DISARM = 3'd2;
  localparam logic [PAT_W-1:0] PAT_DETECT = 3'd3;
  localparam logic [PAT_W-1:0] PAT_RUN    = 3'd4;

  // Step indexes
  localparam logic [STEP_W-1:0] STEP_0 = 2'd0;
  localparam logic [STEP_W-1:0] STEP_1 = 2'd1;
  localparam logic [STEP_W-1:0] STEP_2 = 2'd2;
  localparam logic [STEP_W-1:0] STEP_3 = 2'd3;

  // Wait reloads: duration in ms minus one
  localparam logic [WAIT_W-1:0] WAIT_100  = 11'd99;
  localparam logic [WAIT_W-1:0] WAIT_300  = 11'd299;
  localparam logic [WAIT_W-1:0] WAIT_500  = 11'd499;
  localparam logic [WAIT_W-1:0] WAIT_1000 = 11'd999;
  localparam logic [WAIT_W-1:0] WAIT_1500 = 11'd1499;

  typedef struct packed {
    logic [PAT_W-1:0]  cur_pat;
    logic [PAT_W-1:0]  req_pat;
    logic [STEP_W-1:0] step_idx;
    logic [WAIT_W-1:0] wait_cnt;
    logic              buzzer;
  } seq_state_t;

  typedef struct packed {
    logic             buzzer_on;
    logic [PAT_W-1:0] active_pattern;
    logic             step_taken;
  } seq_result_t;

endpackage

// ----- rtl/abps_if.sv -----
interface abps_in_if import abps_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [PAT_W-1:0] pattern;

  modport source (output valid, cmd, pattern, input ready);
  modport sink   (input valid, cmd, pattern, output ready);
endinterface

interface abps_out_if import abps_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             buzzer_on;
  logic [PAT_W-1:0] active_pattern;
  logic             step_taken;

  modport source (output valid, buzzer_on, active_pattern, step_taken, input ready);
  modport sink   (input valid, buzzer_on, active_pattern, step_taken, output ready);
endinterface

// ----- rtl/alarm_beep_pattern_sequencer_core.sv -----
// Buzzer pattern sequencer: each input beat is a 1 ms tick, a pattern request or a
// reset-to-off, and each one yields exactly one result beat with the buzzer level,
// the playing pattern and whether the tick ran a pattern step. Throughput is one
// beat per clock while the result side keeps ready high; an accepted beat passes
// through the input register, then the combinational step decoder, into the result
// register, and a stalled result holds the input stage.
// Durations are counted in ticks, not clocks; the 11-bit wait counter reloads with
// the step length minus one, so a step fires on the tick that finds it at zero.
`include "alarm_beep_pattern_sequencer_core_assert.svh"

module alarm_beep_pattern_sequencer_core
  import abps_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  abps_in_if.sink  item,
  abps_out_if.source result
);

  logic             s1_valid;
  logic [CMD_W-1:0] s1_cmd;
  logic [PAT_W-1:0] s1_pat;
  logic             s1_adv;
  logic             proc;
  seq_state_t       st;
  seq_state_t       st_next;
  seq_result_t      res_next;
  seq_result_t      res;
  logic             out_valid;

  // Handshake: input stage moves when the result register is free or draining
  assign s1_adv     = !out_valid || result.ready;
  assign proc       = s1_valid && s1_adv;
  assign item.ready = !rst && (!s1_valid || s1_adv);

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      s1_cmd <= item.cmd;
      s1_pat <= item.pattern;
    end
  end

  abps_step u_step (
    .st      (st),
    .cmd     (s1_cmd),
    .pattern (s1_pat),
    .st_next (st_next),
    .res     (res_next)
  );

  // Sequencer state, updated as the item passes into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{cur_pat: PAT_OFF, req_pat: PAT_OFF, step_idx: STEP_0,
              wait_cnt: '0, buzzer: 1'b0};
    end else if (proc) begin
      st <= st_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      res <= res_next;
    end
  end

  assign result.valid          = out_valid;
  assign result.buzzer_on      = res.buzzer_on;
  assign result.active_pattern = res.active_pattern;
  assign result.step_taken     = res.step_taken;

  // Checks
  `ABPS_ASSERT_NEXT(a_step_reloads, clk, rst, proc && res_next.step_taken, st.wait_cnt != '0)
  `ABPS_ASSERT_NEXT(a_nontick_keeps_wait, clk, rst, proc && s1_cmd != CMD_TICK, $stable(st.wait_cnt))
  `ABPS_ASSERT_NEXT(a_reset_cmd, clk, rst, proc && s1_cmd == CMD_RESET, st.cur_pat == PAT_OFF && st.step_idx == STEP_0)
  `ABPS_ASSERT_NEXT(a_stage_holds, clk, rst, s1_valid && !s1_adv, s1_valid && $stable(s1_cmd))

endmodule

// ----- rtl/abps_step.sv -----
module abps_step
  import abps_pkg::*;
(
  input  seq_state_t       st,
  input  logic [CMD_W-1:0] cmd,
  input  logic [PAT_W-1:0] pattern,
  output seq_state_t       st_next,
  output seq_result_t      res
);

  logic [PAT_W-1:0] pat_sel;
  logic             stepped;

  // Pattern adopted at the start of a step, only from step zero
  assign pat_sel = (st.cur_pat != st.req_pat && st.step_idx == STEP_0) ?
                   st.req_pat : st.cur_pat;

  always_comb begin
    st_next = st;
    stepped = 1'b0;
    case (cmd)
      CMD_TICK: begin
        if (st.wait_cnt == '0) begin
          stepped = 1'b1;
          st_next.cur_pat = pat_sel;
          case (pat_sel)
            PAT_ARM: begin
              case (st.step_idx)
                STEP_1: begin
                  st_next.buzzer = 1'b0; st_next.wait_cnt = WAIT_500; st_next.step_idx = STEP_2;
                end
                STEP_2: begin
                  st_next.buzzer = 1'b1; st_next.wait_cnt = WAIT_1000; st_next.step_idx = STEP_3;
                end
                STEP_3: begin
                  st_next.buzzer = 1'b0; st_next.wait_cnt = WAIT_100; st_next.step_idx = STEP_0;
                  st_next.req_pat = PAT_OFF;
                end
                default: begin
                  st_next.buzzer = 1'b1; st_next.wait_cnt = WAIT_300; st_next.step_idx = STEP_1;
                end
              endcase
            end
            PAT_DISARM: begin
              if (st.step_idx == STEP_1) begin
                st_next.buzzer = 1'b0; st_next.wait_cnt = WAIT_100; st_next.step_idx = STEP_0;
                st_next.req_pat = PAT_OFF;
              end else begin
                st_next.buzzer = 1'b1; st_next.wait_cnt = WAIT_1500; st_next.step_idx = STEP_1;
              end
            end
            PAT_DETECT: begin
              if (st.step_idx == STEP_1) begin
                st_next.buzzer = 1'b0; st_next.wait_cnt = WAIT_300; st_next.step_idx = STEP_0;
              end else begin
                st_next.buzzer = 1'b1; st_next.wait_cnt = WAIT_300; st_next.step_idx = STEP_1;
              end
            end
            PAT_RUN: begin
              if (st.step_idx == STEP_1) begin
                st_next.buzzer = 1'b0; st_next.wait_cnt = WAIT_500; st_next.step_idx = STEP_0;
              end else begin
                st_next.buzzer = 1'b1; st_next.wait_cnt = WAIT_1000; st_next.step_idx = STEP_1;
              end
            end
            // off: buzzer and step index left alone, re-poll
            default: st_next.wait_cnt = WAIT_100;
          endcase
        end else begin
          st_next.wait_cnt = st.wait_cnt - 1'b1;
        end
      end
      CMD_REQ: begin
        if (pattern <= PAT_RUN) st_next.req_pat = pattern;
      end
      CMD_RESET: begin
        st_next.cur_pat  = PAT_OFF;
        st_next.req_pat  = PAT_OFF;
        st_next.step_idx = STEP_0;
      end
      default: ;
    endcase
  end

  assign res.buzzer_on      = st_next.buzzer;
  assign res.active_pattern = st_next.cur_pat;
  assign res.step_taken     = stepped;

endmodule

// ----- tb/testbench.sv -----
module testbench;
  import abps_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Codes the package leaves out: the spare command and the unused pattern range
  localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'd3;
  localparam logic [PAT_W-1:0] PAT_BAD_LO  = 3'd5;
  localparam logic [PAT_W-1:0] PAT_BAD_MID = 3'd6;
  localparam logic [PAT_W-1:0] PAT_BAD_HI  = 3'd7;

  // Receiver hold-off length and session plan
  localparam int HOLD_CYCLES = 80;
  localparam int SESSIONS    = 16;
  localparam int CALM_FROM   = 13;

  // Tracks the buzzer sequencer and keeps the results it still owes
  class beep_scoreboard;
    logic [PAT_W-1:0]  cur_pat;
    logic [PAT_W-1:0]  req_pat;
    logic [STEP_W-1:0] step_idx;
    logic [WAIT_W-1:0] wait_cnt;
    logic              buzzer;
    seq_result_t       owed_q[$];
    int                errors;

    function new();
      cur_pat  = PAT_OFF;
      req_pat  = PAT_OFF;
      step_idx = STEP_0;
      wait_cnt = '0;
      buzzer   = 1'b0;
      errors   = 0;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    function void play(logic lvl, logic [WAIT_W-1:0] reload, logic [STEP_W-1:0] nxt);
      buzzer   = lvl;
      wait_cnt = reload;
      step_idx = nxt;
    endfunction

    // One pattern step; a new pattern is only picked up at step zero
    function void pattern_step();
      if (cur_pat != req_pat && step_idx == STEP_0)
        cur_pat = req_pat;
      case (cur_pat)
        PAT_ARM: begin
          case (step_idx)
            STEP_1: play(1'b0, WAIT_500, STEP_2);
            STEP_2: play(1'b1, WAIT_1000, STEP_3);
            STEP_3: begin
              play(1'b0, WAIT_100, STEP_0);
              req_pat = PAT_OFF;
            end
            default: play(1'b1, WAIT_300, STEP_1);
          endcase
        end
        PAT_DISARM: begin
          if (step_idx == STEP_1) begin
            play(1'b0, WAIT_100, STEP_0);
            req_pat = PAT_OFF;
          end else begin
            play(1'b1, WAIT_1500, STEP_1);
          end
        end
        PAT_DETECT: begin
          if (step_idx == STEP_1) play(1'b0, WAIT_300, STEP_0);
          else play(1'b1, WAIT_300, STEP_1);
        end
        PAT_RUN: begin
          if (step_idx == STEP_1) play(1'b0, WAIT_500, STEP_0);
          else play(1'b1, WAIT_1000, STEP_1);
        end
        // off: buzzer and step index left alone, poll again later
        default: wait_cnt = WAIT_100;
      endcase
    endfunction

    // Accepted input beat: advance the state and queue the result it owes
    function void note_beat(logic [CMD_W-1:0] cmd, logic [PAT_W-1:0] pat);
      logic stepped;
      stepped = 1'b0;
      case (cmd)
        CMD_TICK: begin
          if (wait_cnt == '0) begin
            pattern_step();
            stepped = 1'b1;
          end else begin
            wait_cnt = wait_cnt - 1'b1;
          end
        end
        CMD_REQ: begin
          if (pat <= PAT_RUN) req_pat = pat;
        end
        CMD_RESET: begin
          cur_pat  = PAT_OFF;
          req_pat  = PAT_OFF;
          step_idx = STEP_0;
        end
        default: ;
      endcase
      owed_q.push_back('{buzzer_on: buzzer, active_pattern: cur_pat, step_taken: stepped});
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    // Accepted result beat against the oldest owed result
    task check_beat(seq_result_t got);
      seq_result_t exp;
      if (owed_q.size() == 0) begin
        report($sformatf("result beat with nothing owed (%p)", got));
        return;
      end
      exp = owed_q.pop_front();
      if (got.buzzer_on !== exp.buzzer_on)
        report($sformatf("buzzer_on got %b exp %b", got.buzzer_on, exp.buzzer_on));
      if (got.active_pattern !== exp.active_pattern)
        report($sformatf("active_pattern got %0d exp %0d",
                         got.active_pattern, exp.active_pattern));
      if (got.step_taken !== exp.step_taken)
        report($sformatf("step_taken got %b exp %b", got.step_taken, exp.step_taken));
    endtask
  endclass

  logic clk;
  logic rst;
  bit   calm;
  bit   hold_req;
  int   hold_cnt;
  int   stall_cnt;

  beep_scoreboard sb;

  abps_in_if  cmd_ch ();
  abps_out_if res_ch ();

  alarm_beep_pattern_sequencer_core dut (
    .clk    (clk),
    .rst    (rst),
    .item   (cmd_ch),
    .result (res_ch)
  );

  // Clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Hard stop
  initial begin
    #10_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  // Result side: check accepted beats, stall in bursts, one long hold-off on request
  initial begin
    res_ch.ready = 1'b0;
    hold_cnt = 0;
    stall_cnt = 0;
    forever begin
      @(posedge clk);
      if (!rst && res_ch.valid && res_ch.ready)
        sb.check_beat('{buzzer_on: res_ch.buzzer_on, active_pattern: res_ch.active_pattern,
                        step_taken: res_ch.step_taken});
      if (hold_cnt > 0) begin
        hold_cnt--;
        res_ch.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = HOLD_CYCLES - 1;
        res_ch.ready <= 1'b0;
      end else if (stall_cnt > 0) begin
        stall_cnt--;
        res_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_cnt = $urandom_range(0, 4);
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // Offer one beat, maybe after an idle burst, and return at its accepting edge
  task send_beat(logic [CMD_W-1:0] cmd, logic [PAT_W-1:0] pat);
    if (!calm && $urandom_range(0, 9) == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    cmd_ch.valid   <= 1'b1;
    cmd_ch.cmd     <= cmd;
    cmd_ch.pattern <= pat;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    sb.note_beat(cmd, pat);
  endtask

  // Stop offering until every owed result has come back
  task wait_drained();
    cmd_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // One session: maybe a reset, a request, then a run of ticks with rare noise
  task play_session(bit long_run);
    int               n;
    logic [PAT_W-1:0] pat;
    if ($urandom_range(0, 5) == 0) send_beat(CMD_RESET, PAT_W'($urandom_range(0, 7)));
    if (long_run)
      pat = PAT_W'($urandom_range(PAT_ARM, PAT_RUN));
    else if ($urandom_range(0, 9) == 0)
      pat = PAT_W'($urandom_range(PAT_BAD_LO, PAT_BAD_HI));
    else
      pat = PAT_W'($urandom_range(PAT_OFF, PAT_RUN));
    send_beat(CMD_REQ, pat);
    n = long_run ? $urandom_range(1500, 1700) : $urandom_range(1, 20);
    repeat (n) begin
      // long runs keep to requests so whole patterns play out, fall back included
      if (long_run && $urandom_range(0, 299) == 0)
        send_beat(CMD_REQ, PAT_W'($urandom_range(0, 7)));
      else if (!long_run && $urandom_range(0, 29) == 0)
        send_beat(CMD_W'($urandom_range(CMD_REQ, CMD_UNUSED)), PAT_W'($urandom_range(0, 7)));
      else
        send_beat(CMD_TICK, PAT_W'($urandom_range(0, 7)));
    end
  endtask

  initial begin
    sb = new();
    calm = 1'b0;
    hold_req = 1'b0;
    rst = 1'b1;
    cmd_ch.valid   = 1'b0;
    cmd_ch.cmd     = CMD_TICK;
    cmd_ch.pattern = PAT_OFF;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: arm starts at once since the wait counter comes out of reset at zero
    send_beat(CMD_REQ, PAT_ARM);
    send_beat(CMD_TICK, PAT_OFF);
    send_beat(CMD_TICK, PAT_BAD_HI);
    // requests while arm plays, spare command, out-of-range patterns
    send_beat(CMD_REQ, PAT_DISARM);
    send_beat(CMD_UNUSED, PAT_BAD_HI);
    send_beat(CMD_UNUSED, PAT_OFF);
    send_beat(CMD_REQ, PAT_BAD_LO);
    send_beat(CMD_REQ, PAT_BAD_MID);
    send_beat(CMD_REQ, PAT_BAD_HI);
    // reset mid-pattern: buzzer stays on, pattern goes off
    send_beat(CMD_RESET, PAT_RUN);
    send_beat(CMD_TICK, PAT_OFF);
    send_beat(CMD_REQ, PAT_RUN);
    send_beat(CMD_REQ, PAT_DETECT);
    send_beat(CMD_REQ, PAT_OFF);
    send_beat(CMD_REQ, PAT_DISARM);
    send_beat(CMD_TICK, PAT_DISARM);
    send_beat(CMD_RESET, PAT_OFF);
    send_beat(CMD_TICK, PAT_OFF);

    // Random sessions; one of them long enough to play a pattern through
    for (int s = 0; s < SESSIONS; s++) begin
      calm = (s >= CALM_FROM);
      if (s == 2) hold_req = 1'b1;
      if (s == 5 || s == 10) wait_drained();
      play_session(s == 2);
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (sb.errors == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule
